// ===== rtl/core/hrhc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrhc_pkg
// Shared types, codes and keyword tables for the HTTP request head checker.
// ----------------------------------------------------------------------------
package hrhc_pkg;

  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowH  = 8'h68;

  localparam logic [3:0] MethodLen  = 4'd3;
  localparam logic [3:0] PrefixLen  = 4'd7;
  localparam logic [3:0] VersionLen = 4'd8;

  // verdict / status codes
  typedef enum logic [1:0] {
    VD_NEED = 2'd0,
    VD_GOOD = 2'd1,
    VD_BAD  = 2'd2
  } verdict_e;

  // position within the request line
  typedef enum logic [4:0] {
    PH_METHOD = 5'b00001,
    PH_BLANK1 = 5'b00010,
    PH_URL    = 5'b00100,
    PH_BLANK2 = 5'b01000,
    PH_VER    = 5'b10000
  } phase_e;

  // URL form check
  typedef enum logic [4:0] {
    UC_START  = 5'b00001,
    UC_PREFIX = 5'b00010,
    UC_WAIT   = 5'b00100,
    UC_GOOD   = 5'b01000,
    UC_BAD    = 5'b10000
  } url_e;

  typedef struct packed {
    logic       section;       // 0 request line, 1 headers
    phase_e     phase;
    logic [3:0] match_count;
    url_e       url_check;
    logic       line_valid;
    logic       after_cr;
    logic       line_nonempty;
    verdict_e   verdict;
  } state_t;

  localparam state_t StateReset = '{
    section:       1'b0,
    phase:         PH_METHOD,
    match_count:   4'd0,
    url_check:     UC_START,
    line_valid:    1'b1,
    after_cr:      1'b0,
    line_nonempty: 1'b0,
    verdict:       VD_NEED
  };

  // lower-case A..Z only
  function automatic logic [7:0] fold(input logic [7:0] b);
    if (b >= 8'h41 && b <= 8'h5A) begin
      return b + 8'd32;
    end
    return b;
  endfunction

  function automatic logic [7:0] method_char(input logic [1:0] idx);
    unique case (idx)
      2'd0:    return 8'h67; // g
      2'd1:    return 8'h65; // e
      default: return 8'h74; // t
    endcase
  endfunction

  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    return 8'h68; // h
      3'd1:    return 8'h74; // t
      3'd2:    return 8'h74; // t
      3'd3:    return 8'h70; // p
      3'd4:    return 8'h3A; // :
      3'd5:    return 8'h2F; // /
      default: return 8'h2F; // /
    endcase
  endfunction

  function automatic logic [7:0] version_char(input logic [2:0] idx);
    unique case (idx)
      3'd0:    return 8'h68; // h
      3'd1:    return 8'h74; // t
      3'd2:    return 8'h74; // t
      3'd3:    return 8'h70; // p
      3'd4:    return 8'h2F; // /
      3'd5:    return 8'h31; // 1
      3'd6:    return 8'h2E; // .
      default: return 8'h31; // 1
    endcase
  endfunction

endpackage

// ===== rtl/core/hrhc_step.sv =====
// ----------------------------------------------------------------------------
// hrhc_step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module hrhc_step (
  input  hrhc_pkg::state_t cur_i,
  input  logic [7:0]       byte_i,
  input  logic             restart_i,
  output hrhc_pkg::state_t nxt_o,
  output logic             done_o
);

  hrhc_pkg::state_t s;
  hrhc_pkg::state_t n;
  logic             blank;
  logic [7:0]       fb;
  hrhc_pkg::url_e   url_in;
  logic [3:0]       url_mc_in;
  hrhc_pkg::url_e   url_out;
  logic [3:0]       url_mc_out;
  logic [3:0]       ver_mc_in;
  logic             ver_ok;
  logic             line_ok;

  assign s         = restart_i ? hrhc_pkg::StateReset : cur_i;
  assign blank     = (byte_i == hrhc_pkg::ChSpace) || (byte_i == hrhc_pkg::ChTab);
  assign fb        = hrhc_pkg::fold(byte_i);

  assign url_in    = (s.phase == hrhc_pkg::PH_BLANK1) ? hrhc_pkg::UC_START : s.url_check;
  assign url_mc_in = (s.phase == hrhc_pkg::PH_BLANK1) ? 4'd0 : s.match_count;
  assign ver_mc_in = (s.phase == hrhc_pkg::PH_VER) ? s.match_count : 4'd0;
  assign ver_ok    = !ver_mc_in[3] && (fb == hrhc_pkg::version_char(ver_mc_in[2:0]));
  assign line_ok   = s.line_valid && (s.phase == hrhc_pkg::PH_VER) &&
                     (s.match_count == hrhc_pkg::VersionLen) &&
                     (s.url_check == hrhc_pkg::UC_GOOD);

  // URL byte handling, used both on the first URL byte and within the URL
  always_comb begin
    url_out    = url_in;
    url_mc_out = url_mc_in;
    unique case (url_in)
      hrhc_pkg::UC_START: begin
        if (byte_i == hrhc_pkg::ChSlash) begin
          url_out = hrhc_pkg::UC_GOOD;
        end else if (fb == hrhc_pkg::ChLowH) begin
          url_out    = hrhc_pkg::UC_PREFIX;
          url_mc_out = 4'd1;
        end else begin
          url_out = hrhc_pkg::UC_BAD;
        end
      end
      hrhc_pkg::UC_PREFIX: begin
        if (url_mc_in < hrhc_pkg::PrefixLen &&
            fb == hrhc_pkg::prefix_char(url_mc_in[2:0])) begin
          url_mc_out = url_mc_in + 4'd1;
          if (url_mc_in + 4'd1 == hrhc_pkg::PrefixLen) begin
            url_out = hrhc_pkg::UC_WAIT;
          end
        end else begin
          url_out = hrhc_pkg::UC_BAD;
        end
      end
      hrhc_pkg::UC_WAIT: begin
        if (byte_i == hrhc_pkg::ChSlash) begin
          url_out = hrhc_pkg::UC_GOOD;
        end
      end
      hrhc_pkg::UC_GOOD: begin
        url_out = hrhc_pkg::UC_GOOD;
      end
      default: begin
        url_out = hrhc_pkg::UC_BAD;
      end
    endcase
  end

  always_comb begin
    n      = s;
    done_o = 1'b0;

    if (s.verdict == hrhc_pkg::VD_NEED) begin
      if (s.after_cr) begin
        if (byte_i == hrhc_pkg::ChLf) begin
          done_o = 1'b1;
          if (!s.section) begin
            if (line_ok) begin
              n.section = 1'b1;
            end else begin
              n.verdict = hrhc_pkg::VD_BAD;
            end
          end else if (!s.line_nonempty) begin
            n.verdict = hrhc_pkg::VD_GOOD;
          end
          n.phase         = hrhc_pkg::PH_METHOD;
          n.match_count   = 4'd0;
          n.url_check     = hrhc_pkg::UC_START;
          n.line_valid    = 1'b1;
          n.after_cr      = 1'b0;
          n.line_nonempty = 1'b0;
        end else begin
          n.verdict = hrhc_pkg::VD_BAD;
        end
      end else if (byte_i == hrhc_pkg::ChCr) begin
        n.after_cr = 1'b1;
      end else if (byte_i == hrhc_pkg::ChLf) begin
        n.verdict = hrhc_pkg::VD_BAD;
      end else begin
        n.line_nonempty = 1'b1;
        if (!s.section) begin
          unique case (s.phase)
            hrhc_pkg::PH_METHOD: begin
              if (blank) begin
                if (s.match_count == hrhc_pkg::MethodLen) begin
                  n.phase = hrhc_pkg::PH_BLANK1;
                end else begin
                  n.line_valid = 1'b0;
                end
              end else if (s.match_count < hrhc_pkg::MethodLen &&
                           fb == hrhc_pkg::method_char(s.match_count[1:0])) begin
                n.match_count = s.match_count + 4'd1;
              end else begin
                n.line_valid = 1'b0;
              end
            end
            hrhc_pkg::PH_BLANK1: begin
              if (!blank) begin
                n.phase       = hrhc_pkg::PH_URL;
                n.url_check   = url_out;
                n.match_count = url_mc_out;
              end
            end
            hrhc_pkg::PH_URL: begin
              if (blank) begin
                n.phase = hrhc_pkg::PH_BLANK2;
              end else begin
                n.url_check   = url_out;
                n.match_count = url_mc_out;
              end
            end
            hrhc_pkg::PH_BLANK2: begin
              if (!blank) begin
                n.phase = hrhc_pkg::PH_VER;
                if (ver_ok) begin
                  n.match_count = 4'd1;
                end else begin
                  n.match_count = 4'd0;
                  n.line_valid  = 1'b0;
                end
              end
            end
            hrhc_pkg::PH_VER: begin
              if (ver_ok) begin
                n.match_count = s.match_count + 4'd1;
              end else begin
                n.line_valid = 1'b0;
              end
            end
            default: begin
              n.line_valid = 1'b0;
            end
          endcase
        end
      end
    end
    nxt_o = n;
  end

endmodule

// ===== rtl/core/http_request_head_checker_unit.sv =====
// ----------------------------------------------------------------------------
// http_request_head_checker_unit
// Byte-serial checker for the head of an HTTP/1.1 GET request.
// ----------------------------------------------------------------------------
// Feed the request one byte per transfer on the slave stream; every byte gives
// exactly one result transfer on the master stream, in order. The status says
// whether more bytes are needed (0), a complete valid GET request has been seen
// (1) or the request is bad (2); once non-zero it holds until a byte arrives with
// the restart flag set, which clears all state before that byte is checked.
// tlast on the result marks a byte that closed a CR LF line. The block takes one
// byte every clock cycle as long as the result side keeps taking transfers: a
// byte accepted sits in the input register, and the parser state and the result
// register take its outcome when it moves on, which it does while the result
// register is empty or its result is being taken.
// ----------------------------------------------------------------------------
module http_request_head_checker_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  // request bytes
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tuser_i,   // [0] restart
  // results
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,   // [1:0] status, [7:2] zero
  output logic       m_axis_tlast_o    // line_done
);

  // input register
  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       in_restart_q;

  // parser state
  hrhc_pkg::state_t st_q, st_d;

  // result register
  logic       out_valid_q, out_valid_d;
  logic [1:0] out_status_q;
  logic       out_done_q;

  logic       adv;      // input register moves into the result register
  logic       take_in;
  logic       step_done;

  assign adv     = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign take_in = s_axis_tvalid_i && s_axis_tready_o;

  assign s_axis_tready_o = !in_valid_q || adv;

  hrhc_step u_step (
    .cur_i     (st_q),
    .byte_i    (in_byte_q),
    .restart_i (in_restart_q),
    .nxt_o     (st_d),
    .done_o    (step_done)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (take_in) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      st_q        <= hrhc_pkg::StateReset;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (adv) begin
        st_q <= st_d;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q    <= s_axis_tdata_i;
      in_restart_q <= s_axis_tuser_i;
    end
    if (adv) begin
      out_status_q <= st_d.verdict;
      out_done_q   <= step_done;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_status_q};
  assign m_axis_tlast_o  = out_done_q;

  // a verdict, once reached, survives every byte until a restart
  a_verdict_holds : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv && !in_restart_q && (st_q.verdict != hrhc_pkg::VD_NEED)
      |=> st_q.verdict == $past(st_q.verdict)
  ) else $error("verdict changed without restart");

  // a completed line leaves the line trackers at their start values
  a_line_restart : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    adv && step_done |=> !st_q.after_cr && !st_q.line_nonempty &&
                         (st_q.phase == hrhc_pkg::PH_METHOD)
  ) else $error("line state not cleared after CR LF");

  // header lines never move the request-line tracker
  a_headers_idle : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    st_q.section |-> (st_q.phase == hrhc_pkg::PH_METHOD)
  ) else $error("request-line phase moved in header section");

  // a result is only offered with its status within the code range, and a line-done result leaves no CR pending
  a_status_range : assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_status_q != 2'd3) && !(out_done_q && st_q.after_cr)
  ) else $error("illegal result");

endmodule
